// ----- rtl/core/scvs_pkg.sv -----
package scvs_pkg;

	localparam int MaxStrips = 32;
	localparam int IdxW = 5;
	localparam int CntW = 6;
	localparam int AdcBits = 10;
	localparam int StripW = 12;
	localparam int TolW = 8;
	localparam int MinSplit = 3;
	localparam int MaxResults = 16;
	localparam int SumW = AdcBits + CntW;
	localparam int ProdW = SumW + 8;
	localparam logic [TolW-1:0] TolReset = 8'd51;

	typedef struct packed {
		logic [StripW-1:0] base;
		logic [CntW-1:0] count;
	} scvs_job_t;

	typedef struct packed {
		logic last_result;
		logic no_split;
		logic end_half;
		logic start_half;
		logic [StripW-1:0] end_strip;
		logic [StripW-1:0] start_strip;
	} scvs_res_t;

	localparam scvs_res_t NoSplitRes = '{last_result: 1'b1, no_split: 1'b1, end_half: 1'b0,
		start_half: 1'b0, end_strip: '0, start_strip: '0};

endpackage

// ----- rtl/core/scvs_front.sv -----
module scvs_front
	import scvs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [StripW-1:0] in_first,
	input  logic [AdcBits-1:0] in_adc,
	input  logic in_last,
	output logic wr_en,
	output logic [IdxW-1:0] wr_idx,
	output logic [AdcBits-1:0] wr_data,
	output logic job_valid,
	input  logic job_ready,
	output scvs_job_t job
);

	logic [CntW-1:0] count_q;
	logic [StripW-1:0] base_q;
	logic pend_q;
	scvs_job_t job_q;
	logic acc;

	assign in_ready = !pend_q && job_ready;
	assign acc = in_valid && in_ready;
	assign wr_en = acc && (count_q < CntW'(MaxStrips));
	assign wr_idx = count_q[IdxW-1:0];
	assign wr_data = in_adc;
	assign job_valid = pend_q;
	assign job = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			base_q <= '0;
			pend_q <= 1'b0;
		end else begin
			if (pend_q && job_ready) begin
				pend_q <= 1'b0;
			end
			if (acc) begin
				if (in_last) begin
					count_q <= '0;
					pend_q <= 1'b1;
				end else if (count_q < CntW'(MaxStrips)) begin
					count_q <= count_q + 1'b1;
				end
				if (count_q == '0) begin
					base_q <= in_first;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && in_last) begin
			job_q.base <= (count_q == '0) ? in_first : base_q;
			job_q.count <= (count_q < CntW'(MaxStrips)) ? count_q + 1'b1 : count_q;
		end
	end

endmodule

// ----- rtl/core/scvs_back.sv -----
module scvs_back
	import scvs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic [TolW-1:0] tol,
	input  logic wr_en,
	input  logic [IdxW-1:0] wr_idx,
	input  logic [AdcBits-1:0] wr_data,
	input  logic job_valid,
	output logic job_ready,
	input  scvs_job_t job,
	output logic res_valid,
	input  logic res_ready,
	output scvs_res_t res
);

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_SCAN = 10'b0000000010,
		S_PAIR = 10'b0000000100,
		S_FMIN = 10'b0000001000,
		S_RDL  = 10'b0000010000,
		S_RDR  = 10'b0000100000,
		S_TEST = 10'b0001000000,
		S_CUT  = 10'b0010000000,
		S_OUT  = 10'b0100000000,
		S_WAIT = 10'b1000000000
	} st_t;

	st_t st_q;
	logic [AdcBits-1:0] mem [MaxStrips];
	logic [AdcBits-1:0] rd_q;
	logic [IdxW-1:0] rd_addr;
	logic [IdxW-1:0] maxl [MaxStrips];
	logic [IdxW-1:0] minl [MaxStrips];
	logic [CntW-1:0] nmax_q, nmin_q, n_q, i_q, p_q, j_q, k_q;
	logic [CntW-1:0] left_q, right_q, cnt_q, cur_q;
	logic [StripW-1:0] base_q;
	logic [1:0] dir_q;
	logic [AdcBits-1:0] prev_q, la_q, ra_q;
	logic [SumW-1:0] sum_q;
	logic half_q, fin_q;
	scvs_res_t res_q;
	scvs_res_t out_q;
	logic res_v_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_idx] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	function automatic logic adm(input logic [CntW-1:0] idx, input logic [AdcBits-1:0] a,
			input logic [SumW-1:0] s, input logic [CntW-1:0] c, input logic [TolW-1:0] t);
		logic [SumW-1:0] p;
		logic [SumW-1:0] d;
		begin
			p = SumW'(a) * SumW'(c);
			d = (p > s) ? p - s : s - p;
			adm = (idx < CntW'(MaxStrips)) && (s != '0) &&
				({d, 8'd0} < ProdW'(t) * ProdW'(s));
		end
	endfunction

	logic tl, tr, al, ar;
	logic [IdxW-1:0] lm, rm;
	logic [CntW-1:0] endi;
	assign lm = maxl[p_q[IdxW-1:0]];
	assign rm = maxl[p_q[IdxW-1:0] + 1'b1];
	assign tl = adm(left_q, la_q, sum_q, cnt_q, tol);
	assign tr = adm(right_q, ra_q, sum_q, cnt_q, tol);
	assign al = tl && (left_q > CntW'(lm));
	assign ar = tr && (right_q < CntW'(rm));
	assign endi = left_q + (cnt_q >> 1);

	always_comb begin
		rd_addr = i_q[IdxW-1:0];
		case (st_q)
			S_FMIN:  rd_addr = minl[j_q[IdxW-1:0]];
			S_RDL:   rd_addr = (cnt_q == CntW'(1) && j_q != '1) ? left_q[IdxW-1:0] :
				right_q[IdxW-1:0];
			S_WAIT:  rd_addr = left_q[IdxW-1:0];
			default: rd_addr = i_q[IdxW-1:0];
		endcase
	end

	assign job_ready = (st_q == S_IDLE);
	assign res_valid = res_v_q;
	assign res = out_q;

	function automatic scvs_res_t mk(input logic [StripW-1:0] b, input logic [CntW-1:0] s,
			input logic [CntW-1:0] e, input logic sh, input logic eh, input logic lr);
		scvs_res_t r;
		begin
			r.start_strip = b + StripW'(s);
			r.end_strip = b + StripW'(e);
			r.start_half = sh;
			r.end_half = eh;
			r.no_split = 1'b0;
			r.last_result = lr;
			mk = r;
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			res_v_q <= 1'b0;
			fin_q <= 1'b0;
		end else begin
			if (res_v_q && res_ready && st_q != S_OUT) res_v_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (job_valid) begin
						base_q <= job.base;
						n_q <= job.count;
						i_q <= '0;
						nmax_q <= '0;
						nmin_q <= '0;
						dir_q <= 2'd0;
						k_q <= '0;
						p_q <= '0;
						cur_q <= '0;
						half_q <= 1'b0;
						if (job.count < CntW'(MinSplit)) begin
							res_q <= NoSplitRes;
							fin_q <= 1'b1;
							st_q <= S_OUT;
						end else begin
							st_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// Strip i is read; rd_q holds it in the next cycle.
					i_q <= i_q + 1'b1;
					prev_q <= rd_q;
					if (i_q >= CntW'(2)) begin
						if (prev_q < rd_q) begin
							if (dir_q != 2'd1) begin
								dir_q <= 2'd1;
								minl[nmin_q[IdxW-1:0]] <= IdxW'(i_q - 2'd2);
								nmin_q <= nmin_q + 1'b1;
							end
							if (i_q == n_q) begin
								maxl[nmax_q[IdxW-1:0]] <= IdxW'(i_q - 1'b1);
								nmax_q <= nmax_q + 1'b1;
							end
						end else if (prev_q > rd_q) begin
							if (dir_q != 2'd2) begin
								dir_q <= 2'd2;
								maxl[nmax_q[IdxW-1:0]] <= IdxW'(i_q - 2'd2);
								nmax_q <= nmax_q + 1'b1;
							end
							if (i_q == n_q) begin
								minl[nmin_q[IdxW-1:0]] <= IdxW'(i_q - 1'b1);
								nmin_q <= nmin_q + 1'b1;
							end
						end
					end
					if (i_q == n_q) st_q <= S_PAIR;
				end
				S_PAIR: begin
					j_q <= '0;
					if (p_q + 1'b1 >= nmax_q || k_q >= CntW'(MaxResults - 1)) begin
						if (k_q == '0) begin
							res_q <= NoSplitRes;
						end else begin
							res_q <= mk(base_q, cur_q, n_q - 1'b1, half_q, 1'b0, 1'b1);
						end
						fin_q <= 1'b1;
						st_q <= S_OUT;
					end else begin
						st_q <= S_FMIN;
					end
				end
				S_FMIN: begin
					if (j_q >= nmin_q) begin
						p_q <= p_q + 1'b1;
						st_q <= S_PAIR;
					end else if (minl[j_q[IdxW-1:0]] > lm && minl[j_q[IdxW-1:0]] < rm) begin
						left_q <= CntW'(minl[j_q[IdxW-1:0]]) - 1'b1;
						right_q <= CntW'(minl[j_q[IdxW-1:0]]) + 1'b1;
						cnt_q <= CntW'(1);
						st_q <= S_RDL;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_RDL: begin
					// rd_q now holds amplitude at m (or after first pass, left).
					if (cnt_q == CntW'(1) && j_q != '1) begin
						sum_q <= SumW'(rd_q);
						j_q <= '1;
					end else begin
						la_q <= rd_q;
						st_q <= S_RDR;
					end
				end
				S_RDR: begin
					ra_q <= rd_q;
					st_q <= S_TEST;
				end
				S_TEST: begin
					if ((tl && !al) || (tr && !ar)) begin
						p_q <= p_q + 1'b1;
						st_q <= S_PAIR;
					end else if (!al && !ar) begin
						st_q <= S_CUT;
					end else begin
						sum_q <= sum_q + (al ? SumW'(la_q) : '0) + (ar ? SumW'(ra_q) : '0);
						cnt_q <= cnt_q + CntW'(al) + CntW'(ar);
						if (al) left_q <= left_q - 1'b1;
						if (ar) right_q <= right_q + 1'b1;
						st_q <= S_WAIT;
					end
				end
				S_CUT: begin
					if (cnt_q[0]) begin
						res_q <= mk(base_q, cur_q, endi + 1'b1, half_q, 1'b1, 1'b0);
						half_q <= 1'b1;
					end else begin
						res_q <= mk(base_q, cur_q, endi, half_q, 1'b0, 1'b0);
						half_q <= 1'b0;
					end
					cur_q <= endi + 1'b1;
					k_q <= k_q + 1'b1;
					p_q <= p_q + 1'b1;
					fin_q <= 1'b0;
					st_q <= S_OUT;
				end
				S_OUT: begin
					if (!res_v_q || res_ready) begin
						out_q <= res_q;
						res_v_q <= 1'b1;
						st_q <= fin_q ? S_IDLE : S_PAIR;
					end
				end
				S_WAIT: st_q <= S_RDL;
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/strip_cluster_valley_splitter_top.sv -----
// Channel  Direction  Content
// s_axis   in         tdata: first_strip[11:0], adc[21:12]; tlast: last
// m_axis   out        tdata: start_strip, end_strip, start_half, end_half, no_split
//                     (bits 0 up, 27 used); tlast: last_result
// cfg      in         tolerance_q8 write, applied at the next edge
// Strips load at one per cycle while no job is pending and the back end is idle. A
// cluster's split pass runs the extrema scan, then per pair of maxima a search over the
// minima, a flatness test of the valley neighbors and a cut, all through one memory read port.
// While a cluster waits or is being split, the front accepts no strip. Results leave
// through one output register. Reset clears the front counters, the valid flags and the back-end state.
module strip_cluster_valley_splitter_top
	import scvs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [23:0] s_axis_tdata, // first_strip, adc, 2 unused bits
	input  logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [31:0] m_axis_tdata, // start_strip, end_strip, start_half, end_half, no_split
	output logic m_axis_tlast
);

	logic [TolW-1:0] tol_q;
	logic wr_en;
	logic [IdxW-1:0] wr_idx;
	logic [AdcBits-1:0] wr_data;
	logic job_valid, job_ready;
	scvs_job_t job;
	scvs_res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tol_q <= TolReset;
		else if (cfg_we) tol_q <= cfg_wdata;
	end

	scvs_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_first(s_axis_tdata[11:0]), .in_adc(s_axis_tdata[21:12]), .in_last(s_axis_tlast),
		.wr_en, .wr_idx, .wr_data, .job_valid, .job_ready, .job
	);

	scvs_back u_back (
		.clk, .arst_n, .tol(tol_q), .wr_en, .wr_idx, .wr_data,
		.job_valid, .job_ready, .job,
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
	);

	assign m_axis_tdata = {5'd0, res.no_split, res.end_half, res.start_half,
		res.end_strip, res.start_strip};
	assign m_axis_tlast = res.last_result;

endmodule

// ----- rtl/core/scvs_checker.sv -----
module scvs_checker (
	input logic clk,
	input logic arst_n,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic m_axis_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Output changed while stalled.");

	a_ns_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[26] |-> m_axis_tlast)
		else $error("No-split record is not final.");

	a_ns_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[26] |-> m_axis_tdata[25:0] == 26'd0)
		else $error("No-split record carries a range.");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[31:27] == 5'd0)
		else $error("Padding bits set.");

endmodule

bind strip_cluster_valley_splitter_top scvs_checker u_chk (.*);
